// ===== src/tic_pkg.sv =====
// ============================================================================
// Tensor index/coordinate conversion package
// Shared constants, register indexes and pipeline control types for the
// flat index to coordinate converter.
// ============================================================================
package tic_pkg;

   // Default shape limits, handed to the top level as parameter defaults.
   localparam int MAX_RANK_DEF   = 6;
   localparam int DIM_BITS_DEF   = 16;
   localparam int INDEX_BITS_DEF = 32;

   // Width of the rank register.
   localparam int RANK_BITS = 3;

   // Register indexes on the configuration port.
   localparam int REG_RANK     = 0;
   localparam int REG_DIM_BASE = 1;

   // Conversion direction carried with every request.
   typedef enum logic [0:0] {
      FUNC_FOLD  = 1'b0,   // coordinates to flat index
      FUNC_SPLIT = 1'b1    // flat index to coordinates
   } func_type;

   // Control travelling down the chain beside the payload.
   typedef struct packed {
      logic     valid;
      func_type func;
      logic     flag;
   } ctl_type;

endpackage

// ===== src/tic_div_cell.sv =====
// ============================================================================
// Division step cell
// One restoring long-division step: shifts one dividend bit into the
// remainder held in the coordinate slot of its dimension and produces one
// quotient bit. A row of these splits the flat index by one dimension size.
// ============================================================================
module tic_div_cell #(
   parameter int MAX_RANK   = tic_pkg::MAX_RANK_DEF,
   parameter int DIM_BITS   = tic_pkg::DIM_BITS_DEF,
   parameter int INDEX_BITS = tic_pkg::INDEX_BITS_DEF,
   parameter int DIM        = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               active,
   input  logic [DIM_BITS-1:0]                divisor,
   input  tic_pkg::ctl_type                   src_ctl,
   input  logic [INDEX_BITS-1:0]              src_value,
   input  logic [MAX_RANK-1:0][DIM_BITS-1:0]  src_coords,
   output tic_pkg::ctl_type                   dst_ctl,
   output logic [INDEX_BITS-1:0]              dst_value,
   output logic [MAX_RANK-1:0][DIM_BITS-1:0]  dst_coords
);
   import tic_pkg::*;

   ctl_type                              ctl_ff, ctl_in;
   logic [INDEX_BITS-1:0]                value_ff, value_in;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]    coords_ff, coords_in;
   logic [DIM_BITS:0]                    trial;
   logic [DIM_BITS:0]                    diff;
   logic                                 take;

   always_comb begin
      ctl_in    = src_ctl;
      value_in  = src_value;
      coords_in = src_coords;
      // The remainder stays below the divisor, so the trial fits one extra bit.
      trial = {src_coords[DIM], src_value[INDEX_BITS-1]};
      diff  = trial - {1'b0, divisor};
      take  = (trial >= {1'b0, divisor});
      if (src_ctl.valid && (src_ctl.func == FUNC_SPLIT) && active) begin
         value_in       = {src_value[INDEX_BITS-2:0], take};
         coords_in[DIM] = take ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff  <= value_in;
         coords_ff <= coords_in;
      end
   end

   assign dst_ctl    = ctl_ff;
   assign dst_value  = value_ff;
   assign dst_coords = coords_ff;

endmodule

// ===== src/tic_fold_cell.sv =====
// ============================================================================
// Horner step cell
// One step of folding coordinates into a flat index: adds coordinate K to
// the running index, registers, then multiplies by the size of the next
// faster dimension and registers again, raising the flag on overflow.
// ============================================================================
module tic_fold_cell #(
   parameter int MAX_RANK   = tic_pkg::MAX_RANK_DEF,
   parameter int DIM_BITS   = tic_pkg::DIM_BITS_DEF,
   parameter int INDEX_BITS = tic_pkg::INDEX_BITS_DEF,
   parameter int K          = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic [DIM_BITS-1:0]                factor,
   input  tic_pkg::ctl_type                   src_ctl,
   input  logic [INDEX_BITS-1:0]              src_value,
   input  logic [MAX_RANK-1:0][DIM_BITS-1:0]  src_coords,
   output tic_pkg::ctl_type                   dst_ctl,
   output logic [INDEX_BITS-1:0]              dst_value,
   output logic [MAX_RANK-1:0][DIM_BITS-1:0]  dst_coords
);
   import tic_pkg::*;

   localparam int PROD_BITS = INDEX_BITS + DIM_BITS;

   ctl_type                              mid_ctl_ff, mid_ctl_in;
   logic [INDEX_BITS-1:0]                mid_value_ff, mid_value_in;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]    mid_coords_ff;
   ctl_type                              ctl_ff, ctl_in;
   logic [INDEX_BITS-1:0]                value_ff, value_in;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]    coords_ff;
   logic [INDEX_BITS:0]                  sum;
   logic [PROD_BITS-1:0]                 prod;

   // Addition stage.
   always_comb begin
      mid_ctl_in   = src_ctl;
      mid_value_in = src_value;
      sum = {1'b0, src_value} + (INDEX_BITS + 1)'(src_coords[K]);
      if (src_ctl.valid && (src_ctl.func == FUNC_FOLD)) begin
         mid_value_in    = sum[INDEX_BITS-1:0];
         mid_ctl_in.flag = src_ctl.flag | sum[INDEX_BITS];
      end
   end

   // Multiplication stage.
   always_comb begin
      ctl_in   = mid_ctl_ff;
      value_in = mid_value_ff;
      prod = PROD_BITS'(mid_value_ff) * PROD_BITS'(factor);
      if (mid_ctl_ff.valid && (mid_ctl_ff.func == FUNC_FOLD)) begin
         value_in    = prod[INDEX_BITS-1:0];
         ctl_in.flag = mid_ctl_ff.flag | (|prod[PROD_BITS-1:INDEX_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ctl_ff.valid <= 1'b0;
         ctl_ff.valid     <= 1'b0;
      end else if (en) begin
         mid_ctl_ff <= mid_ctl_in;
         ctl_ff     <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_value_ff  <= mid_value_in;
         mid_coords_ff <= src_coords;
         value_ff      <= value_in;
         coords_ff     <= mid_coords_ff;
      end
   end

   assign dst_ctl    = ctl_ff;
   assign dst_value  = value_ff;
   assign dst_coords = coords_ff;

endmodule

// ===== src/tensor_index_coordinate_convert_top.sv =====
// ============================================================================
// Tensor index/coordinate converter
// Mixed-radix conversion between a flat element index and per-dimension
// coordinates of a tensor whose shape is held in configuration registers.
// ============================================================================
// The block takes one request per clock cycle and returns one result for each
// request, in order. A request passes through a chain of MAX_RANK groups, each
// holding one two-stage Horner cell and INDEX_BITS one-bit division cells, then
// an output register. The chain's length is set by the one-quotient-bit-per-cell
// division of the index by every dimension size. The chain stalls only while
// its last cell holds a result and the output register is still waiting to be
// taken. Dimension 0 varies fastest; a rank of 0 acts as 1 and a rank above
// MAX_RANK as MAX_RANK. Coordinates above the rank are ignored on requests and
// returned as zero. A size of zero in use acts as one and raises range_flag,
// as does an index that overflows or does not fit the shape.
module tensor_index_coordinate_convert_top #(
   parameter int MAX_RANK   = tic_pkg::MAX_RANK_DEF,
   parameter int DIM_BITS   = tic_pkg::DIM_BITS_DEF,
   parameter int INDEX_BITS = tic_pkg::INDEX_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // Configuration write port.
   input  logic                                       csr_we,
   input  logic [$clog2(MAX_RANK+1)-1:0]              csr_index,
   input  logic [DIM_BITS-1:0]                        csr_wdata,
   // Request channel.
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // req_tdata, lowest bit up: flat_index_in, coord_in_0 .. coord_in_5.
   input  logic [((INDEX_BITS+MAX_RANK*DIM_BITS+7)/8)*8-1:0] req_tdata,
   // req_tuser: func.
   input  logic                                       req_tuser,
   // Result channel.
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // rsp_tdata, lowest bit up: flat_index_out, coord_out_0 .. coord_out_5.
   output logic [((INDEX_BITS+MAX_RANK*DIM_BITS+7)/8)*8-1:0] rsp_tdata,
   // rsp_tuser: range_flag.
   output logic                                       rsp_tuser
);
   import tic_pkg::*;

   localparam int CSR_IDX_BITS = $clog2(MAX_RANK + 1);
   localparam int DATA_BITS    = ((INDEX_BITS + MAX_RANK * DIM_BITS + 7) / 8) * 8;
   localparam int GROUP_NODES  = INDEX_BITS + 1;
   localparam int NODES        = MAX_RANK * GROUP_NODES + 1;
   localparam int LAST         = NODES - 1;

   // Configuration registers.
   logic [RANK_BITS-1:0]  rank_ff;
   logic [DIM_BITS-1:0]   dim_size_ff [MAX_RANK];

   // Shape as seen by the arithmetic.
   logic [MAX_RANK-1:0]   dim_used;
   logic [MAX_RANK-1:0]   size_zero;
   logic [DIM_BITS-1:0]   size_eff    [MAX_RANK];
   logic [DIM_BITS-1:0]   fold_factor [MAX_RANK];
   logic                  zero_size;

   // Chain nodes.
   ctl_type                              node_ctl    [NODES];
   logic [INDEX_BITS-1:0]                node_value  [NODES];
   logic [MAX_RANK-1:0][DIM_BITS-1:0]    node_coords [NODES];

   logic                                 en;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]    req_coords;
   func_type                             req_func;

   // Output register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]                rsp_flat_ff, rsp_flat_in;
   logic [MAX_RANK-1:0][DIM_BITS-1:0]    rsp_coords_ff, rsp_coords_in;
   logic                                 rsp_flag_ff, rsp_flag_in;

   // ---------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_BITS'(1);
         for (int j = 0; j < MAX_RANK; j++) begin
            dim_size_ff[j] <= DIM_BITS'(1);
         end
      end else if (csr_we) begin
         if (csr_index == CSR_IDX_BITS'(REG_RANK)) begin
            rank_ff <= csr_wdata[RANK_BITS-1:0];
         end
         for (int j = 0; j < MAX_RANK; j++) begin
            if (csr_index == CSR_IDX_BITS'(REG_DIM_BASE + j)) begin
               dim_size_ff[j] <= csr_wdata;
            end
         end
      end
   end

   for (genvar j = 0; j < MAX_RANK; j++) begin : g_shape
      // Dimension 0 is always in use; a rank above the limit uses them all.
      if (j == 0) begin : g_first
         assign dim_used[j] = 1'b1;
      end else begin : g_rest
         assign dim_used[j] = (rank_ff > RANK_BITS'(j));
      end
      assign size_zero[j] = (dim_size_ff[j] == '0);
      assign size_eff[j]  = size_zero[j] ? DIM_BITS'(1) : dim_size_ff[j];
   end

   assign zero_size = |(dim_used & size_zero);

   // ---------------------------------------------------------------------
   // Chain entry
   // ---------------------------------------------------------------------
   assign en         = !node_ctl[LAST].valid || !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign req_coords = req_tdata[INDEX_BITS +: MAX_RANK * DIM_BITS];
   assign req_func   = func_type'(req_tuser);

   always_comb begin
      node_ctl[0].valid = req_tvalid;
      node_ctl[0].func  = req_func;
      node_ctl[0].flag  = 1'b0;
      // The index register starts as the dividend when splitting and as the
      // Horner accumulator at zero when folding; the coordinate slots start
      // as coordinates to fold or as zero remainders.
      node_value[0] = (req_func == FUNC_SPLIT) ? req_tdata[INDEX_BITS-1:0] : '0;
      for (int j = 0; j < MAX_RANK; j++) begin
         node_coords[0][j] = ((req_func == FUNC_FOLD) && dim_used[j]) ?
                             req_coords[j] : '0;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain: per dimension one Horner cell and a row of division cells
   // ---------------------------------------------------------------------
   for (genvar j = 0; j < MAX_RANK; j++) begin : g_group
      localparam int BASE = j * GROUP_NODES;
      localparam int K    = MAX_RANK - 1 - j;

      // Horner runs from the slowest dimension down to dimension 0.
      if (K >= 1) begin : g_factor
         assign fold_factor[j] = size_eff[K-1];
      end else begin : g_unit
         assign fold_factor[j] = DIM_BITS'(1);
      end

      tic_fold_cell #(
         .MAX_RANK   (MAX_RANK),
         .DIM_BITS   (DIM_BITS),
         .INDEX_BITS (INDEX_BITS),
         .K          (K)
      ) u_fold (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .factor     (fold_factor[j]),
         .src_ctl    (node_ctl[BASE]),
         .src_value  (node_value[BASE]),
         .src_coords (node_coords[BASE]),
         .dst_ctl    (node_ctl[BASE+1]),
         .dst_value  (node_value[BASE+1]),
         .dst_coords (node_coords[BASE+1])
      );

      for (genvar b = 0; b < INDEX_BITS; b++) begin : g_bit
         tic_div_cell #(
            .MAX_RANK   (MAX_RANK),
            .DIM_BITS   (DIM_BITS),
            .INDEX_BITS (INDEX_BITS),
            .DIM        (j)
         ) u_div (
            .clock      (clock),
            .reset      (reset),
            .en         (en),
            .active     (dim_used[j]),
            .divisor    (size_eff[j]),
            .src_ctl    (node_ctl[BASE+1+b]),
            .src_value  (node_value[BASE+1+b]),
            .src_coords (node_coords[BASE+1+b]),
            .dst_ctl    (node_ctl[BASE+2+b]),
            .dst_value  (node_value[BASE+2+b]),
            .dst_coords (node_coords[BASE+2+b])
         );
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = (rsp_valid_ff && !rsp_tready) || (en && node_ctl[LAST].valid);
      rsp_flat_in   = (node_ctl[LAST].func == FUNC_FOLD) ? node_value[LAST] : '0;
      rsp_coords_in = (node_ctl[LAST].func == FUNC_SPLIT) ? node_coords[LAST] : '0;
      // A quotient left after the last dimension means the index lies outside.
      rsp_flag_in   = node_ctl[LAST].flag | zero_size |
                      ((node_ctl[LAST].func == FUNC_SPLIT) && (|node_value[LAST]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && node_ctl[LAST].valid) begin
         rsp_flat_ff   <= rsp_flat_in;
         rsp_coords_ff <= rsp_coords_in;
         rsp_flag_ff   <= rsp_flag_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'({rsp_coords_ff, rsp_flat_ff});
   assign rsp_tuser  = rsp_flag_ff;

   // Checks on the arithmetic at the end of the chain.
   logic [MAX_RANK-1:0] hi_coord_set;
   logic [MAX_RANK-1:0] rem_too_big;

   always_comb begin
      for (int j = 0; j < MAX_RANK; j++) begin
         hi_coord_set[j] = !dim_used[j] && (rsp_coords_ff[j] != '0);
         rem_too_big[j]  = dim_used[j] && (node_coords[LAST][j] >= size_eff[j]);
      end
   end

`ifndef NO_ASSERTIONS
   a_hi_coords_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (hi_coord_set == '0))
      else $error("coordinate above the rank is not zero");

   a_remainder_below_size : assert property (@(posedge clock) disable iff (reset)
      (node_ctl[LAST].valid && (node_ctl[LAST].func == FUNC_SPLIT))
         |-> (rem_too_big == '0))
      else $error("split coordinate not below its dimension size");

   a_one_direction : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_flat_ff != '0)) |-> (rsp_coords_ff == '0))
      else $error("result carries both an index and coordinates");
`endif

endmodule
